/* rtl/sha256_stream_hasher_macros.svh */
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

`ifndef SYNTHESIS
`define SHA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 assertion failed");
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 assertion failed");
`else
`define SHA_ASSERT_IMPLY(label, ante, cons)
`define SHA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/sha_pkg.sv */
// Types, constants and round functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps

package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } sha_state_t;

  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [5:0] PadLast   = 6'd55;
  localparam logic [5:0] BlockLast = 6'd63;
  localparam logic [5:0] RoundLast = 6'd63;
  localparam logic [2:0] WordLast  = 3'd7;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* rtl/sha256_stream_hasher.sv */
// SHA-256 stream hasher: byte intake, padding, iterative round unit, digest output.
//
//   channel   ports                       carries
//   input     in_valid/in_ready/in_data   at most one message byte with end flag
//   output    out_valid/out_ready/out_data one digest word, eight per message
//
// A byte item is written straight into the block; the 64th byte of a block starts its rounds and a fold.
// An end item then brings pad bytes through byte 55, the length words, the compression and
// the eight output words, one per word taken; a pad that runs past
// byte 55 fills to byte 63 and costs one more compression and a fresh block of pads.
// Reset is synchronous; the block accepts items in the first cycle after it.
// in_ready is low while a block compresses and from an end item until the last word leaves.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_macros.svh"

module sha256_stream_hasher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha_pkg::sha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  sha_state_t  state_r, state_nxt;
  logic [5:0]  fill_r;
  logic [63:0] msg_len_r;
  logic [5:0]  round_r;
  logic [2:0]  word_idx_r;
  logic        mark_r;
  logic        resume_pad_r;
  logic        final_r;
  logic [31:0] chain_r [8];
  logic [31:0] work_r [8];
  logic [31:0] w_r [16];

  logic        in_acc;
  logic        out_acc;
  logic [7:0]  pad_byte;
  logic [31:0] t1, t2, w_new;
  logic [63:0] bit_len;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign pad_byte = mark_r ? PadMark : 8'h00;
  assign bit_len  = {msg_len_r[60:0], 3'b000};

  assign t1 = work_r[7] + big_sigma1(work_r[4])
            + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
            + RoundK[round_r] + w_r[0];
  assign t2 = big_sigma0(work_r[0])
            + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));
  assign w_new = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (in_data.has_byte && fill_r == BlockLast) begin
            state_nxt = ST_ROUND;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_r == BlockLast) begin
          state_nxt = ST_ROUND;
        end else if (fill_r == PadLast) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (round_r == RoundLast) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (resume_pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (out_acc && word_idx_r == WordLast) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready             = 1'b0;
    out_valid            = 1'b0;
    out_data.digest_word = chain_r[word_idx_r];
    out_data.word_index  = word_idx_r;
    out_data.last_word   = (word_idx_r == WordLast);
    case (state_r)
      ST_LOAD: in_ready  = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      fill_r       <= '0;
      msg_len_r    <= '0;
      round_r      <= '0;
      word_idx_r   <= '0;
      mark_r       <= 1'b0;
      resume_pad_r <= 1'b0;
      final_r      <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= InitHash[i];
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (in_data.has_byte) begin
              fill_r    <= fill_r + 6'd1;
              msg_len_r <= msg_len_r + 64'd1;
            end
            mark_r       <= in_data.end_of_message;
            resume_pad_r <= in_data.end_of_message;
            final_r      <= 1'b0;
          end
        end
        ST_PAD: begin
          fill_r       <= fill_r + 6'd1;
          mark_r       <= 1'b0;
          resume_pad_r <= 1'b1;
        end
        ST_LEN: begin
          fill_r  <= '0;
          final_r <= 1'b1;
        end
        ST_ROUND: round_r <= round_r + 6'd1;
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain_r[i] <= chain_r[i] + work_r[i];
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            word_idx_r <= word_idx_r + 3'd1;
            if (word_idx_r == WordLast) begin
              msg_len_r <= '0;
              final_r   <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                chain_r[i] <= InitHash[i];
              end
            end
          end
        end
        default: round_r <= '0;
      endcase
    end
  end

  // message schedule window and byte lanes
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_data.has_byte) begin
          w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= in_data.data_byte;
        end
      end
      ST_PAD: w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= pad_byte;
      ST_LEN: begin
        w_r[14] <= bit_len[63:32];
        w_r[15] <= bit_len[31:0];
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_r[i] <= w_r[i + 1];
        end
        w_r[15] <= w_new;
      end
      default: w_r[0] <= w_r[0];
    endcase
  end

  // working words: hold a copy of the chain until rounds begin
  always_ff @(posedge clk) begin
    if (state_r == ST_ROUND) begin
      work_r[0] <= t1 + t2;
      work_r[1] <= work_r[0];
      work_r[2] <= work_r[1];
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3] + t1;
      work_r[5] <= work_r[4];
      work_r[6] <= work_r[5];
      work_r[7] <= work_r[6];
    end else begin
      for (int i = 0; i < 8; i++) begin
        work_r[i] <= chain_r[i];
      end
    end
  end

  `SHA_ASSERT_IMPLY(a_no_overlap, in_ready, !out_valid)
  `SHA_ASSERT_IMPLY(a_round_idle, state_r != ST_ROUND, round_r == '0)
  `SHA_ASSERT_IMPLY(a_len_pos, state_r == ST_LEN, fill_r == LenPos)
  `SHA_ASSERT_NEXT(a_rounds_done, state_r == ST_ROUND && round_r == RoundLast, state_r == ST_FOLD)
  `SHA_ASSERT_NEXT(a_restart, out_acc && word_idx_r == WordLast,
                   state_r == ST_LOAD && msg_len_r == '0 && fill_r == '0)

endmodule

/* tb/sha256_stream_hasher_tb.sv */
// Self-checking testbench for the SHA-256 stream hasher with a built-in digest predictor.
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;
  import sha_pkg::*;

  localparam int ItemTarget  = 320;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 200;
  localparam int ChunkBytes  = 64;
  localparam int LengthSlot  = 56;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [255:0] DigestEmpty =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] DigestAbc =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    sha_in_t      item;
    logic         typed;
    logic [255:0] digest;
  } step_row_t;

  localparam int DirCount = 15;
  localparam step_row_t Directed [DirCount] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, DigestEmpty},
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h63, 1'b1, 1'b1}, 1'b1, DigestAbc},
    '{'{8'hff, 1'b0, 1'b1}, 1'b1, DigestEmpty},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, 256'h0},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'ha5, 1'b0, 1'b0}, 1'b0, 256'h0},
    '{'{8'h80, 1'b1, 1'b1}, 1'b0, 256'h0},
    '{'{8'h5a, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'hc3, 1'b0, 1'b1}, 1'b0, 256'h0},
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h63, 1'b0, 1'b1}, 1'b0, 256'h0}
  };

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_PATTERN,
    READY_RANDOM
  } ready_mode_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sha_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sha_out_t out_data;

  logic [31:0] chain_h [8];
  logic [7:0]  chunk_buf [ChunkBytes];
  int          fill_cnt;
  logic [63:0] msg_len;

  sha_out_t words_due [$];
  int       mismatch_cnt = 0;
  int       item_cnt = 0;
  int       msg_cnt = 0;
  int       word_cnt = 0;
  int       cycle_cnt = 0;
  int       burst_left = 0;

  sha256_stream_hasher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  task automatic clear_hash_state();
    chain_h  = StartHash;
    foreach (chunk_buf[i]) chunk_buf[i] = 8'h00;
    fill_cnt = 0;
    msg_len  = 64'd0;
  endtask

  task automatic compress_chunk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {chunk_buf[4*i], chunk_buf[4*i+1], chunk_buf[4*i+2], chunk_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = chain_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] += v[i];
  endtask

  task automatic hash_item(input sha_in_t item, input logic typed, input logic [255:0] digest);
    logic [63:0] bits;
    sha_out_t    word;
    if (item.has_byte) begin
      chunk_buf[fill_cnt] = item.data_byte;
      fill_cnt++;
      msg_len++;
      if (fill_cnt == ChunkBytes) begin
        compress_chunk();
        fill_cnt = 0;
      end
    end
    if (item.end_of_message) begin
      chunk_buf[fill_cnt] = PadByte;
      fill_cnt++;
      if (fill_cnt > LengthSlot) begin
        for (int i = fill_cnt; i < ChunkBytes; i++) chunk_buf[i] = 8'h00;
        compress_chunk();
        fill_cnt = 0;
      end
      for (int i = fill_cnt; i < LengthSlot; i++) chunk_buf[i] = 8'h00;
      bits = msg_len << 3;
      for (int i = 0; i < 8; i++) chunk_buf[ChunkBytes-1-i] = bits[8*i +: 8];
      compress_chunk();
      for (int i = 0; i < 8; i++) begin
        word.digest_word = typed ? digest[255-32*i -: 32] : chain_h[i];
        word.word_index  = 3'(i);
        word.last_word   = (i == 7);
        words_due = {words_due, word};
      end
      msg_cnt++;
      clear_hash_state();
    end
  endtask

  task automatic push_item(input sha_in_t item, input logic typed, input logic [255:0] digest);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.has_byte || item.end_of_message) item_cnt++;
    hash_item(item, typed, digest);
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    sha_in_t item;
    bit      end_alone;
    end_alone = (len == 0) || ($urandom_range(0, 1) == 1);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        item.data_byte      = 8'($urandom_range(0, 255));
        item.has_byte       = 1'b0;
        item.end_of_message = 1'b0;
        push_item(item, 1'b0, '0);
      end
      item.data_byte      = 8'($urandom_range(0, 255));
      item.has_byte       = 1'b1;
      item.end_of_message = !end_alone && (n == len - 1);
      push_item(item, 1'b0, '0);
    end
    if (end_alone) begin
      item.data_byte      = 8'($urandom_range(0, 255));
      item.has_byte       = 1'b0;
      item.end_of_message = 1'b1;
      push_item(item, 1'b0, '0);
    end
  endtask

  function automatic int pick_length();
    case ($urandom_range(0, 7))
      0: return $urandom_range(119, 121);
      1: return $urandom_range(54, 65);
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  always @(posedge clk) begin
    sha_out_t want;
    if (rst_n && out_valid && out_ready) begin
      word_cnt++;
      if (words_due.size() == 0) begin
        $error("digest word with none expected: %h", out_data.digest_word);
        mismatch_cnt++;
      end else begin
        want = words_due.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, got %h", want.digest_word, out_data.digest_word);
          mismatch_cnt++;
        end
        if (out_data.word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, out_data.word_index);
          mismatch_cnt++;
        end
        if (out_data.last_word !== want.last_word) begin
          $error("last_word: expected %0b, got %0b", want.last_word, out_data.last_word);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, words_due.size());
      $display("[sha256_stream_hasher] ERROR");
      $finish;
    end
  end

  initial begin
    int          tick;
    ready_mode_t mode;
    logic [7:0]  pattern;
    out_ready = 1'b0;
    tick      = 0;
    mode      = READY_ALWAYS;
    pattern   = 8'b1101_0110;
    forever begin
      @(negedge clk);
      if (tick % 40 == 0) mode = ready_mode_t'($urandom_range(0, 2));
      tick++;
      pattern = {pattern[6:0], pattern[7]};
      case (mode)
        READY_ALWAYS:  out_ready <= 1'b1;
        READY_PATTERN: out_ready <= pattern[0];
        default:       out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    int edge_lens [3];
    edge_lens = '{55, 56, 64};
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clear_hash_state();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int r = 0; r < DirCount; r++) begin
      push_item(Directed[r].item, Directed[r].typed, Directed[r].digest);
    end
    foreach (edge_lens[i]) send_message(edge_lens[i]);
    while (item_cnt < ItemTarget) send_message(pick_length());
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("hashed %0d messages from %0d byte/end items, padding across block edges",
             msg_cnt, item_cnt);
    $display("checked %0d digest words under random sender gaps and receiver stalls",
             word_cnt);
    if (mismatch_cnt == 0) begin
      $display("[sha256_stream_hasher] OK");
    end else begin
      $display("[sha256_stream_hasher] ERROR");
    end
    $finish;
  end

endmodule
